>>> hw/rtl/sgi_pkg.sv
// sgi_pkg: shared constants for the segment intersection pipeline.
// No dependencies.
`timescale 1ns / 1ps

package sgi_pkg;

    // default coordinate width; the binary point position does not change
    // any decision or result, so only the width is a design parameter
    localparam int COORD_WIDTH_DEF = 32;
    localparam int COORD_WIDTH_MIN = 8;

endpackage

>>> hw/rtl/segment_intersection_unit.sv
// segment_intersection_unit: pipelined 2-D segment intersection test and point.
// Depends on sgi_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel: i_valid / o_stall with eight signed endpoint coordinates
//   (two segments, a and b). An item is taken when i_valid is high and
//   o_stall is low.
//   Output channel: o_valid / i_stall with o_hit, o_hit_x, o_hit_y. One result
//   leaves for every item, in order. A miss gives zero coordinates.
//   Throughput: one item per cycle while the output is not stalled. Stages:
//   four stages of difference, multiply, determinant and range test, the
//   COORD_WIDTH + 1 divider stages with one quotient bit per stage
//   (radix-2 long division fused with the numerator product), and the
//   output register.
//   Reset (synchronous, active low) clears all valid bits; in-flight items
//   are dropped.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and o_stall rises in the same cycle; nothing is lost or repeated.

module segment_intersection_unit
    import sgi_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_x1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_y1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_x2,
    input  logic signed [COORD_WIDTH-1:0] i_seg_a_y2,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_x1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_y1,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_x2,
    input  logic signed [COORD_WIDTH-1:0] i_seg_b_y2,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_hit,
    output logic signed [COORD_WIDTH-1:0] o_hit_x,
    output logic signed [COORD_WIDTH-1:0] o_hit_y
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;      // coordinate difference
    localparam int PW = 2 * DW;     // product of two differences
    localparam int NW = PW + 1;     // determinant and numerators
    localparam int RW = NW + 1;     // divider partial value

    logic en;
    logic r_vo;

    assign en      = !(r_vo && i_stall);
    assign o_stall = r_vo && i_stall;

    // ---------------- stage 1: differences and box test ----------------
    logic                 r1_v, r1_box;
    logic signed [DW-1:0] r1_dxa, r1_dyb, r1_ex, r1_ey, r1_fx, r1_fy;
    logic        [W-1:0]  r1_bx, r1_by;

    logic signed [DW-1:0] a1, b1, a2, b2, x1, y1, x2, y2;
    logic signed [W-1:0]  max_a, min_a, max_b, min_b, max_x, min_x, max_y, min_y;
    logic                 n1_box;

    always_comb begin
        a1 = DW'(i_seg_a_x1);
        b1 = DW'(i_seg_a_y1);
        a2 = DW'(i_seg_a_x2);
        b2 = DW'(i_seg_a_y2);
        x1 = DW'(i_seg_b_x1);
        y1 = DW'(i_seg_b_y1);
        x2 = DW'(i_seg_b_x2);
        y2 = DW'(i_seg_b_y2);
        max_a = (i_seg_a_x1 > i_seg_a_x2) ? i_seg_a_x1 : i_seg_a_x2;
        min_a = (i_seg_a_x1 < i_seg_a_x2) ? i_seg_a_x1 : i_seg_a_x2;
        max_b = (i_seg_a_y1 > i_seg_a_y2) ? i_seg_a_y1 : i_seg_a_y2;
        min_b = (i_seg_a_y1 < i_seg_a_y2) ? i_seg_a_y1 : i_seg_a_y2;
        max_x = (i_seg_b_x1 > i_seg_b_x2) ? i_seg_b_x1 : i_seg_b_x2;
        min_x = (i_seg_b_x1 < i_seg_b_x2) ? i_seg_b_x1 : i_seg_b_x2;
        max_y = (i_seg_b_y1 > i_seg_b_y2) ? i_seg_b_y1 : i_seg_b_y2;
        min_y = (i_seg_b_y1 < i_seg_b_y2) ? i_seg_b_y1 : i_seg_b_y2;
        n1_box = (max_a >= min_x) && (max_x >= min_a) &&
                 (max_b >= min_y) && (max_y >= min_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= i_valid;
        end
        if (en) begin
            r1_box <= n1_box;
            r1_dxa <= a2 - a1;
            r1_dyb <= b2 - b1;
            r1_ex  <= x1 - x2;
            r1_ey  <= y1 - y2;
            r1_fx  <= x1 - a1;
            r1_fy  <= y1 - b1;
            r1_bx  <= i_seg_a_x1;
            r1_by  <= i_seg_a_y1;
        end
    end

    // ---------------- stage 2: cross products ----------------
    logic                 r2_v, r2_box;
    logic signed [PW-1:0] r2_pd1, r2_pd2, r2_pt1, r2_pt2, r2_ps1, r2_ps2;
    logic signed [DW-1:0] r2_dxa, r2_dyb;
    logic        [W-1:0]  r2_bx, r2_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v <= r1_v;
        end
        if (en) begin
            r2_box <= r1_box;
            r2_pd1 <= PW'(r1_dxa) * PW'(r1_ey);
            r2_pd2 <= PW'(r1_dyb) * PW'(r1_ex);
            r2_pt1 <= PW'(r1_fx) * PW'(r1_ey);
            r2_pt2 <= PW'(r1_fy) * PW'(r1_ex);
            r2_ps1 <= PW'(r1_dxa) * PW'(r1_fy);
            r2_ps2 <= PW'(r1_dyb) * PW'(r1_fx);
            r2_dxa <= r1_dxa;
            r2_dyb <= r1_dyb;
            r2_bx  <= r1_bx;
            r2_by  <= r1_by;
        end
    end

    // ---------------- stage 3: determinant and numerators ----------------
    logic                 r3_v, r3_box;
    logic signed [NW-1:0] r3_det, r3_tn, r3_sn;
    logic signed [DW-1:0] r3_dxa, r3_dyb;
    logic        [W-1:0]  r3_bx, r3_by;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= r2_v;
        end
        if (en) begin
            r3_box <= r2_box;
            r3_det <= NW'(r2_pd1) - NW'(r2_pd2);
            r3_tn  <= NW'(r2_pt1) - NW'(r2_pt2);
            r3_sn  <= NW'(r2_ps1) - NW'(r2_ps2);
            r3_dxa <= r2_dxa;
            r3_dyb <= r2_dyb;
            r3_bx  <= r2_bx;
            r3_by  <= r2_by;
        end
    end

    // ---------------- stage 4: range test, magnitudes ----------------
    // divider pipeline arrays; index 0 is loaded here, index DW is the last step
    logic          r_dv [0:DW];
    logic          r_dh [0:DW];
    logic [NW-1:0] r_dd [0:DW];     // |det|
    logic [NW-1:0] r_dt [0:DW];     // |t numerator|
    logic [DW-1:0] r_mx [0:DW];
    logic [DW-1:0] r_my [0:DW];
    logic          r_nx [0:DW];
    logic          r_ny [0:DW];
    logic [W-1:0]  r_bx [0:DW];
    logic [W-1:0]  r_by [0:DW];
    logic [NW-1:0] r_rx [0:DW];
    logic [NW-1:0] r_ry [0:DW];
    logic [DW-1:0] r_qx [0:DW];
    logic [DW-1:0] r_qy [0:DW];

    logic det_neg, tn_neg, t_ok, s_ok, n4_hit;

    always_comb begin
        det_neg = r3_det[NW-1];
        tn_neg  = r3_tn[NW-1];
        if (!det_neg) begin
            t_ok = !r3_tn[NW-1] && (r3_tn <= r3_det);
            s_ok = !r3_sn[NW-1] && (r3_sn <= r3_det);
        end else begin
            t_ok = (r3_tn <= 0) && (r3_det <= r3_tn);
            s_ok = (r3_sn <= 0) && (r3_det <= r3_sn);
        end
        n4_hit = r3_box && (r3_det != 0) && t_ok && s_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv[0] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r3_v;
        end
        if (en) begin
            r_dh[0] <= n4_hit;
            r_dd[0] <= det_neg ? NW'(-r3_det) : NW'(r3_det);
            r_dt[0] <= tn_neg ? NW'(-r3_tn) : NW'(r3_tn);
            r_mx[0] <= r3_dxa[DW-1] ? DW'(-r3_dxa) : DW'(r3_dxa);
            r_my[0] <= r3_dyb[DW-1] ? DW'(-r3_dyb) : DW'(r3_dyb);
            r_nx[0] <= tn_neg ^ r3_dxa[DW-1] ^ det_neg;
            r_ny[0] <= tn_neg ^ r3_dyb[DW-1] ^ det_neg;
            r_bx[0] <= r3_bx;
            r_by[0] <= r3_by;
            r_rx[0] <= '0;
            r_ry[0] <= '0;
            r_qx[0] <= '0;
            r_qy[0] <= '0;
        end
    end

    // ---------------- divider: floor(|tn| * m / |det|), one bit of m a stage ----
    // V = 2r + bit*|tn| stays below 3*|det|, so each digit is 0, 1 or 2.
    genvar j;
    generate
        for (j = 0; j < DW; j++) begin : g_div
            logic [RW-1:0] vx, vy, d1, d2;
            logic [NW-1:0] n_rx, n_ry;
            logic [1:0]    dgx, dgy;

            always_comb begin
                d1 = RW'(r_dd[j]);
                d2 = {r_dd[j], 1'b0};
                vx = {r_rx[j], 1'b0} + (r_mx[j][DW-1-j] ? RW'(r_dt[j]) : '0);
                vy = {r_ry[j], 1'b0} + (r_my[j][DW-1-j] ? RW'(r_dt[j]) : '0);
                if (vx >= d2) begin
                    n_rx = NW'(vx - d2);
                    dgx  = 2'd2;
                end else if (vx >= d1) begin
                    n_rx = NW'(vx - d1);
                    dgx  = 2'd1;
                end else begin
                    n_rx = NW'(vx);
                    dgx  = 2'd0;
                end
                if (vy >= d2) begin
                    n_ry = NW'(vy - d2);
                    dgy  = 2'd2;
                end else if (vy >= d1) begin
                    n_ry = NW'(vy - d1);
                    dgy  = 2'd1;
                end else begin
                    n_ry = NW'(vy);
                    dgy  = 2'd0;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dv[j+1] <= 1'b0;
                end else if (en) begin
                    r_dv[j+1] <= r_dv[j];
                end
                if (en) begin
                    r_dh[j+1] <= r_dh[j];
                    r_dd[j+1] <= r_dd[j];
                    r_dt[j+1] <= r_dt[j];
                    r_mx[j+1] <= r_mx[j];
                    r_my[j+1] <= r_my[j];
                    r_nx[j+1] <= r_nx[j];
                    r_ny[j+1] <= r_ny[j];
                    r_bx[j+1] <= r_bx[j];
                    r_by[j+1] <= r_by[j];
                    r_rx[j+1] <= n_rx;
                    r_ry[j+1] <= n_ry;
                    r_qx[j+1] <= {r_qx[j][DW-2:0], 1'b0} + DW'(dgx);
                    r_qy[j+1] <= {r_qy[j][DW-2:0], 1'b0} + DW'(dgy);
                end
            end
        end
    endgenerate

    // ---------------- output register ----------------
    logic         r_ho;
    logic [W-1:0] r_xo, r_yo;
    logic [W-1:0] qx, qy;

    assign qx = r_qx[DW][W-1:0];
    assign qy = r_qy[DW][W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en) begin
            r_vo <= r_dv[DW];
        end
        if (en) begin
            r_ho <= r_dh[DW];
            r_xo <= r_dh[DW] ? (r_bx[DW] + (r_nx[DW] ? (~qx + 1'b1) : qx)) : '0;
            r_yo <= r_dh[DW] ? (r_by[DW] + (r_ny[DW] ? (~qy + 1'b1) : qy)) : '0;
        end
    end

    assign o_valid = r_vo;
    assign o_hit   = r_ho;
    assign o_hit_x = r_xo;
    assign o_hit_y = r_yo;

    // ---------------- assertions ----------------
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && !r_ho) |-> (r_xo == '0 && r_yo == '0))
        else $error("miss result with nonzero point");

    a_hit_det: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[0] && r_dh[0]) |-> (r_dd[0] != '0 && r_dt[0] <= r_dd[0]))
        else $error("hit with zero determinant or t outside range");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[DW] && r_dh[DW]) |-> (r_rx[DW] < r_dd[DW] && r_ry[DW] < r_dd[DW]))
        else $error("divider remainder not below divisor");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && i_stall) |=> (r_vo && $stable(r_dv[DW]) && $stable(r_qx[DW])))
        else $error("pipeline advanced while output stalled");

endmodule

>>> dv/tb_segment_intersection_unit.sv
// tb_segment_intersection_unit: self-checking bench for segment_intersection_unit.
// Predicts hit and point with exact wide arithmetic; depends on sgi_pkg and the DUT.
`timescale 1ns / 1ps

module tb_segment_intersection_unit;
    import sgi_pkg::*;

    localparam int W          = COORD_WIDTH_DEF;
    localparam int N_RANDOM   = 1900;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN      = 2 * (W + 6);

    typedef logic signed [W-1:0] coord_t;
    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        coord_t ax1, ay1, ax2, ay2;
        coord_t bx1, by1, bx2, by2;
    } seg_pair_t;

    typedef struct packed {
        logic   hit;
        coord_t x;
        coord_t y;
    } hit_result_t;

    localparam coord_t CMAX = {1'b0, {(W-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(W-1){1'b0}}};

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_valid = 1'b0;
    logic   i_stall = 1'b0;
    coord_t i_seg_a_x1 = '0, i_seg_a_y1 = '0, i_seg_a_x2 = '0, i_seg_a_y2 = '0;
    coord_t i_seg_b_x1 = '0, i_seg_b_y1 = '0, i_seg_b_x2 = '0, i_seg_b_y2 = '0;
    logic   o_stall, o_valid, o_hit;
    coord_t o_hit_x, o_hit_y;

    always #6 i_clk = ~i_clk;

    segment_intersection_unit #(.COORD_WIDTH(W)) dut (.*);

    // t = num/det within [0,1], endpoints included, no division
    function automatic bit param_in_range(wide_t num, wide_t det);
        if (det >= 0)
            return num >= 0 && num <= det;
        return num <= 0 && det <= num;
    endfunction

    // base + num*delta/det, quotient truncated toward zero
    function automatic coord_t lerp_point(wide_t base, wide_t num, wide_t delta, wide_t det);
        wide_t prod, quot;
        bit    neg;
        neg  = (num < 0) ^ (delta < 0) ^ (det < 0);
        prod = (num < 0 ? -num : num) * (delta < 0 ? -delta : delta);
        quot = prod / (det < 0 ? -det : det);
        return coord_t'(base + (neg ? -quot : quot));
    endfunction

    function automatic hit_result_t predict_hit(seg_pair_t p);
        wide_t a1, b1, a2, b2, x1, y1, x2, y2, det, tn, sn;
        hit_result_t r;
        a1 = p.ax1; b1 = p.ay1; a2 = p.ax2; b2 = p.ay2;
        x1 = p.bx1; y1 = p.by1; x2 = p.bx2; y2 = p.by2;
        r = '0;
        if ((a1 > a2 ? a1 : a2) < (x1 < x2 ? x1 : x2) ||
            (x1 > x2 ? x1 : x2) < (a1 < a2 ? a1 : a2) ||
            (b1 > b2 ? b1 : b2) < (y1 < y2 ? y1 : y2) ||
            (y1 > y2 ? y1 : y2) < (b1 < b2 ? b1 : b2))
            return r;
        det = (a2 - a1) * (y1 - y2) - (b2 - b1) * (x1 - x2);
        tn  = (x1 - a1) * (y1 - y2) - (y1 - b1) * (x1 - x2);
        sn  = (a2 - a1) * (y1 - b1) - (b2 - b1) * (x1 - a1);
        if (det == 0 || !param_in_range(tn, det) || !param_in_range(sn, det))
            return r;
        r.hit = 1'b1;
        r.x   = lerp_point(a1, tn, a2 - a1, det);
        r.y   = lerp_point(b1, tn, b2 - b1, det);
        return r;
    endfunction

    class hit_scoreboard;
        hit_result_t pending[$];
        int          errors;
        int          checked;
        int          hits;

        function void note_pair(seg_pair_t p);
            pending.push_back(predict_hit(p));
        endfunction

        function void check_result(hit_result_t got);
            hit_result_t want;
            checked++;
            if (got.hit) hits++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: unexpected result hit=%0d x=%0d y=%0d",
                             got.hit, got.x, got.y);
                return;
            end
            want = pending.pop_front();
            if (got.hit !== want.hit || got.x !== want.x || got.y !== want.y) begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: result %0d: exp hit=%0d x=%0d y=%0d got hit=%0d x=%0d y=%0d",
                             checked, want.hit, want.x, want.y, got.hit, got.x, got.y);
            end
        endfunction
    endclass

    hit_scoreboard sb = new();
    int cyc;
    int idle_cycles;
    int stall_hold;
    int sent;

    // every fourth window of the cycle counter runs without any idling
    function automatic bit quiet_window();
        return (cyc / 300) % 4 == 0;
    endfunction

    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_window() || r < 70) return 0;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin : monitor
        int stall_len;
        cyc <= cyc + 1;
        if (i_rst_n) begin
            if ((o_valid && !i_stall) || (i_valid && !o_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (o_valid && !i_stall)
                sb.check_result('{o_hit, o_hit_x, o_hit_y});
            if (stall_hold > 0) begin
                stall_hold <= stall_hold - 1;
            end else if (i_stall) begin
                // end of a stall run; stay low for a random stretch
                i_stall    <= 1'b0;
                stall_hold <= pick_idle_len();
            end else begin
                stall_len = pick_idle_len();
                if (stall_len > 0) begin
                    i_stall    <= 1'b1;
                    stall_hold <= stall_len - 1;
                end
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic send_pair(seg_pair_t p);
        int gap;
        gap = pick_idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_seg_a_x1 <= p.ax1; i_seg_a_y1 <= p.ay1;
        i_seg_a_x2 <= p.ax2; i_seg_a_y2 <= p.ay2;
        i_seg_b_x1 <= p.bx1; i_seg_b_y1 <= p.by1;
        i_seg_b_x2 <= p.bx2; i_seg_b_y2 <= p.by2;
        do @(posedge i_clk); while (o_stall);
        sb.note_pair(p);
        sent++;
    endtask

    function automatic coord_t near(coord_t c, int span);
        return c + coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    function automatic coord_t extreme_value();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return '0;
            3: return '1;
            4: return coord_t'(1);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic seg_pair_t random_pair();
        seg_pair_t p;
        coord_t    cx, cy;
        int        span, mode;
        mode = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0: span = 16;
            1: span = 1 << 16;
            default: span = 1 << 24;
        endcase
        cx = coord_t'($urandom) >>> 2;
        cy = coord_t'($urandom) >>> 2;
        // crossing pair around a common center
        p.ax1 = cx + coord_t'($urandom_range(0, span)); p.ay1 = cy + coord_t'($urandom_range(0, span));
        p.ax2 = cx - coord_t'($urandom_range(0, span)); p.ay2 = cy - coord_t'($urandom_range(0, span));
        p.bx1 = cx - coord_t'($urandom_range(0, span)); p.by1 = cy + coord_t'($urandom_range(0, span));
        p.bx2 = cx + coord_t'($urandom_range(0, span)); p.by2 = cy - coord_t'($urandom_range(0, span));
        if (mode < 45) begin
        end else if (mode < 55) begin
            // second segment starts on an endpoint of the first
            if ($urandom_range(0, 1)) begin p.bx1 = p.ax1; p.by1 = p.ay1; end
            else begin p.bx1 = p.ax2; p.by1 = p.ay2; end
        end else if (mode < 63) begin
            // parallel or collinear, shifted in x, or b starting at a's midpoint
            p.bx1 = p.ax1 + coord_t'($urandom_range(0, span)) * $urandom_range(0, 1);
            p.by1 = p.ay1;
            p.bx2 = p.bx1 + (p.ax2 - p.ax1);
            p.by2 = p.by1 + (p.ay2 - p.ay1);
            if ($urandom_range(0, 1)) begin
                p.bx1 = p.ax1 + (p.ax2 - p.ax1) / 2; p.by1 = p.ay1 + (p.ay2 - p.ay1) / 2;
            end
        end else if (mode < 68) begin
            p.bx2 = p.bx1; p.by2 = p.by1;
        end else if (mode < 78) begin
            p.bx1 = near(p.bx1, span); p.bx2 = near(p.bx2, span);
            p.by1 = near(p.by1, span); p.by2 = near(p.by2, span);
        end else if (mode < 88) begin
            p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            p.ax1 = extreme_value(); p.ay1 = extreme_value();
            p.ax2 = extreme_value(); p.ay2 = extreme_value();
            p.bx1 = extreme_value(); p.by1 = extreme_value();
            p.bx2 = extreme_value(); p.by2 = extreme_value();
        end
        return p;
    endfunction

    initial begin
        seg_pair_t directed[$];
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full-range diagonals and axes crossing near the origin, edges meeting at a corner
        directed.push_back('{CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN});
        directed.push_back('{CMAX, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX});
        directed.push_back('{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN});
        directed.push_back('{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX});
        directed.push_back('{CMIN, '0, CMAX, '0, '0, CMIN, '0, CMAX});
        // boxes apart
        directed.push_back('{0, 0, 100, 100, 200, 0, 300, 100});
        directed.push_back('{CMIN, CMIN, -1, -1, 0, 0, CMAX, CMAX});
        // parallel, collinear overlapping, degenerate
        directed.push_back('{0, 0, 100, 0, 0, 10, 100, 10});
        directed.push_back('{0, 0, 100, 100, 50, 50, 150, 150});
        directed.push_back('{5, 5, 5, 5, 0, 0, 10, 10});
        directed.push_back('{5, 5, 5, 5, 5, 5, 5, 5});
        directed.push_back('{'0, '0, '0, '0, '0, '0, '0, '0});
        directed.push_back('{'1, '1, '1, '1, '1, '1, '1, '1});
        // touching endpoints: t and s at exactly 0 and 1
        directed.push_back('{0, 0, 100, 0, 0, 0, 0, 100});
        directed.push_back('{0, 0, 100, 0, 100, 0, 100, 100});
        directed.push_back('{0, 0, 100, 0, 50, 100, 50, 0});
        directed.push_back('{0, 0, 100, 0, 50, 0, 50, -100});
        // just missing by one lsb
        directed.push_back('{0, 0, 100, 0, 50, 1, 50, 100});
        // fractional point, negative quotients
        directed.push_back('{0, 0, 3, 7, 3, 0, 0, 5});
        directed.push_back('{-1, -3, -9, -2, -8, -7, 0, 2});
        directed.push_back('{CMAX, 0, CMIN, 1, 0, CMAX, 1, CMIN});
        foreach (directed[k]) send_pair(directed[k]);

        repeat (N_RANDOM) send_pair(random_pair());
        i_valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("Run covered %0d segment pairs (directed extremes, touching, parallel, random).",
                 sent);
        $display("Results checked: %0d, hits: %0d, mismatches: %0d",
                 sb.checked, sb.hits, sb.errors);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/sgi_pkg.sv
hw/rtl/segment_intersection_unit.sv
dv/tb_segment_intersection_unit.sv
